// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the coefficient calculator
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, reset included
`define SOLP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("assertion failed");

// check only outside of reset
`define SOLP_ASSERT_RUN(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error("assertion failed");

`endif

// File: rtl/core/solp_pkg.sv
// ---------------------------------------------------------------------------
// solp_pkg
// shared types and constants of the biquad coefficient calculator
// ---------------------------------------------------------------------------
`default_nettype none

package solp_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int FC_W     = 17;
   localparam int Q_W      = 16;
   localparam int FS_W     = 18;
   localparam int COEF_W   = 28;
   localparam int TURN_W   = 32;
   localparam int CV_W     = 34;
   localparam int C_W      = 32;
   localparam int DS_NW    = 39;
   localparam int BD_W     = 41;
   localparam int BQ_W     = 32;
   localparam int BETA_W   = 35;

   // defaults of the top level parameters
   localparam int COEF_FRAC_BITS_DEF    = 24;
   localparam int CORDIC_ITERATIONS_DEF = 24;

   // constants
   localparam logic [FS_W-1:0]        FS_RESET    = 18'd48000;
   localparam logic [Q_W-1:0]         Q_DEFAULT   = 16'd181;
   localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // filter types
   localparam logic [OP_W-1:0] OP_LPF = 2'd0;
   localparam logic [OP_W-1:0] OP_HPF = 2'd1;

   // atan(2^-i) as a fraction of a full turn, scaled by 2^32
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic [FC_W-1:0] cutoff_hz;
      logic [Q_W-1:0]  quality;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a0;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
      logic signed [COEF_W-1:0] coef_b1;
      logic signed [COEF_W-1:0] coef_b2;
      logic                     computed;
      logic                     overflow;
   } rsp_type;

   // per-transaction control that rides along the cell chain
   typedef struct packed {
      logic                    vld;
      logic [OP_W-1:0]         op;
      logic                    unsup;
      logic                    fs0;
      logic                    flip;
      logic                    sneg;
      logic                    negb;
      logic                    sat;
      logic [Q_W-1:0]          q;
      logic signed [C_W-1:0]   c;
   } side_type;

endpackage

`default_nettype wire

// File: rtl/core/solp_div_cell.sv
// ---------------------------------------------------------------------------
// solp_div_cell
// one restoring division step: shifts in one dividend bit, emits one quotient bit
// ---------------------------------------------------------------------------
`default_nettype none

module solp_div_cell #(
   parameter int NW = 8,
   parameter int DW = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  solp_pkg::side_type side_i,
   input  logic [DW-1:0]      rem_i,
   input  logic [NW-1:0]      nq_i,
   input  logic [DW-1:0]      div_i,
   output solp_pkg::side_type side_o,
   output logic [DW-1:0]      rem_o,
   output logic [NW-1:0]      nq_o,
   output logic [DW-1:0]      div_o
);
   import solp_pkg::*;

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;
   logic [DW-1:0] rem_in, rem_ff;
   logic [NW-1:0] nq_in, nq_ff;
   logic [DW-1:0] div_ff;
   side_type      side_ff;

   // trial subtract of the divisor from the shifted remainder
   assign trial = {rem_i, nq_i[NW-1]};
   assign diff  = trial - {1'b0, div_i};
   assign ge    = (trial >= {1'b0, div_i});

   always_comb begin
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      nq_in  = {nq_i[NW-2:0], ge};
   end

   // hand the step result to the next cell
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      nq_ff   <= nq_in;
      div_ff  <= div_i;
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
   end

   assign rem_o  = rem_ff;
   assign nq_o   = nq_ff;
   assign div_o  = div_ff;
   assign side_o = side_ff;

endmodule

`default_nettype wire

// File: rtl/core/solp_cordic_cell.sv
// ---------------------------------------------------------------------------
// solp_cordic_cell
// one rotation-mode cordic micro-rotation with a fixed shift
// ---------------------------------------------------------------------------
`default_nettype none

module solp_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  solp_pkg::side_type                 side_i,
   input  logic signed [solp_pkg::CV_W-1:0]   x_i,
   input  logic signed [solp_pkg::CV_W-1:0]   y_i,
   input  logic signed [solp_pkg::CV_W-1:0]   a_i,
   output solp_pkg::side_type                 side_o,
   output logic signed [solp_pkg::CV_W-1:0]   x_o,
   output logic signed [solp_pkg::CV_W-1:0]   y_o,
   output logic signed [solp_pkg::CV_W-1:0]   a_o
);
   import solp_pkg::*;

   localparam logic signed [CV_W-1:0] ANG = $signed({{(CV_W-32){1'b0}}, ATAN_TURN[IDX]});

   logic signed [CV_W-1:0] xs, ys;
   logic signed [CV_W-1:0] x_in, y_in, a_in;
   logic signed [CV_W-1:0] x_ff, y_ff, a_ff;
   side_type               side_ff;

   assign xs = x_i >>> IDX;
   assign ys = y_i >>> IDX;

   // rotate toward zero residual angle
   always_comb begin
      if (!a_i[CV_W-1]) begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         a_in = a_i - ANG;
      end else begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         a_in = a_i + ANG;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      a_ff    <= a_in;
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign a_o    = a_ff;
   assign side_o = side_ff;

endmodule

`default_nettype wire

// File: rtl/core/solp_coef_calc.sv
// ---------------------------------------------------------------------------
// solp_coef_calc
// gamma product, alpha and the five rounded, saturated coefficients
// ---------------------------------------------------------------------------
`default_nettype none

module solp_coef_calc #(
   parameter int COEF_FRAC_BITS = solp_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  solp_pkg::side_type                   side_i,
   input  logic signed [solp_pkg::BETA_W-1:0]   beta_i,
   output logic                                 strobe_o,
   output solp_pkg::rsp_type                    rsp_o
);
   import solp_pkg::*;

   localparam int SH    = 30 - COEF_FRAC_BITS;
   localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
   localparam logic signed [41:0] RND      = (SH > 0) ? (42'sd1 <<< SH_M1) : 42'sd0;
   localparam logic signed [41:0] COEF_HI  = 42'sd134217727;
   localparam logic signed [41:0] COEF_LO  = -42'sd134217728;
   localparam logic signed [41:0] HALF_Q30 = 42'sd536870912;

   // round half up to the output format and saturate, msb is the overflow flag
   function automatic logic [COEF_W:0] to_coef(input logic signed [41:0] v);
      logic signed [41:0] r;
      logic               o;
      r = (v + RND) >>> SH;
      o = 1'b0;
      if (r > COEF_HI) begin
         r = COEF_HI;
         o = 1'b1;
      end
      if (r < COEF_LO) begin
         r = COEF_LO;
         o = 1'b1;
      end
      return {o, r[COEF_W-1:0]};
   endfunction

   logic signed [BETA_W:0]     hb;
   logic signed [C_W+BETA_W:0] prod_in, prod_ff;
   logic signed [BETA_W-1:0]   beta_ff;
   side_type                   side_ff;

   // stage 1: (0.5 + beta) * cos
   assign hb      = $signed({beta_i[BETA_W-1], beta_i}) + $signed(HALF_Q30[BETA_W:0]);
   assign prod_in = hb * side_i.c;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      beta_ff <= beta_i;
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
   end

   logic signed [41:0]  gamma, beta_w, sum, alpha, a1, b1, b2;
   logic [COEF_W:0]     ca0, ca1, cb1, cb2;
   rsp_type             rsp_in, rsp_ff;
   logic                strobe_ff;

   // stage 2: alpha and coefficient formatting
   always_comb begin
      gamma  = 42'(prod_ff >>> 30);
      beta_w = 42'(beta_ff);
      if (side_ff.op == OP_LPF) begin
         sum = HALF_Q30 + beta_w - gamma;
      end else begin
         sum = HALF_Q30 + beta_w + gamma;
      end
      alpha = sum >>> 1;
      if (side_ff.op == OP_LPF) begin
         a1 = alpha <<< 1;
      end else begin
         a1 = -(alpha <<< 1);
      end
      b1  = -(gamma <<< 1);
      b2  = beta_w <<< 1;
      ca0 = to_coef(alpha);
      ca1 = to_coef(a1);
      cb1 = to_coef(b1);
      cb2 = to_coef(b2);
      rsp_in = '0;
      if (side_ff.unsup) begin
         rsp_in = '0;
      end else if (side_ff.fs0) begin
         rsp_in.overflow = 1'b1;
      end else begin
         rsp_in.coef_a0  = ca0[COEF_W-1:0];
         rsp_in.coef_a1  = ca1[COEF_W-1:0];
         rsp_in.coef_a2  = ca0[COEF_W-1:0];
         rsp_in.coef_b1  = cb1[COEF_W-1:0];
         rsp_in.coef_b2  = cb2[COEF_W-1:0];
         rsp_in.computed = 1'b1;
         rsp_in.overflow = side_ff.sat | ca0[COEF_W] | ca1[COEF_W]
                         | cb1[COEF_W] | cb2[COEF_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= side_ff.vld;
      end
   end

   assign strobe_o = strobe_ff;
   assign rsp_o    = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/second_order_lpf_hpf_coefficient_calc_unit.sv
// ---------------------------------------------------------------------------
// second_order_lpf_hpf_coefficient_calc_unit
// low-pass / high-pass biquad coefficients from type, cutoff and q
// ---------------------------------------------------------------------------
// usage
//   req channel: a transaction is taken at a clock edge with start high and
//   busy low. busy is high only while reset is asserted.
//   rsp channel: rsp_strobe is high for one cycle with the coefficients on
//   rsp_data. the receiver has no way to stall and must take it then.
//   csr channel: csr_data is the sample rate in hertz, written when csr_valid
//   and csr_ready are high. write it only while no transaction is in flight.
// timing
//   the datapath is a row of cells, one register per step: 17 remainder steps,
//   32 angle quotient steps, CORDIC_ITERATIONS rotations, 39 q division steps
//   and 32 beta division steps plus a few join stages.
//   a new transaction is accepted every cycle while busy is low.
// reset
//   synchronous reset clears the in-flight transactions and sets the sample
//   rate to 48000 hz.
// ---------------------------------------------------------------------------
`default_nettype none

module second_order_lpf_hpf_coefficient_calc_unit #(
   parameter int COEF_FRAC_BITS    = solp_pkg::COEF_FRAC_BITS_DEF,
   parameter int CORDIC_ITERATIONS = solp_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  solp_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output solp_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [solp_pkg::FS_W-1:0]  csr_data
);
   import solp_pkg::*;

   localparam int LATENCY = 1 + FC_W + TURN_W + 1 + CORDIC_ITERATIONS + 1
                          + DS_NW + 1 + 1 + BQ_W + 1 + 2;

   logic            accept;
   logic [FS_W-1:0] rate_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // sample rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= FS_RESET;
      end else if (csr_valid && csr_ready) begin
         rate_ff <= csr_data;
      end
   end

   // input stage
   side_type        s0_in, s0_ff;
   logic [FC_W-1:0] fc0_ff;

   always_comb begin
      s0_in       = '0;
      s0_in.vld   = accept;
      s0_in.op    = req_data.opcode;
      s0_in.unsup = (req_data.opcode != OP_LPF) && (req_data.opcode != OP_HPF);
      s0_in.fs0   = (rate_ff == '0);
      s0_in.q     = (req_data.quality == '0) ? Q_DEFAULT : req_data.quality;
   end

   always_ff @(posedge clock) begin
      fc0_ff <= req_data.cutoff_hz;
      if (reset) begin
         s0_ff <= '0;
      end else begin
         s0_ff <= s0_in;
      end
   end

   // cutoff modulo sample rate
   side_type        m_side [0:FC_W];
   logic [FS_W-1:0] m_rem  [0:FC_W];
   logic [FC_W-1:0] m_nq   [0:FC_W];
   logic [FS_W-1:0] m_div  [0:FC_W];

   assign m_side[0] = s0_ff;
   assign m_rem[0]  = '0;
   assign m_nq[0]   = fc0_ff;
   assign m_div[0]  = rate_ff;

   for (genvar k = 0; k < FC_W; k++) begin : g_mod
      solp_div_cell #(.NW(FC_W), .DW(FS_W)) u_cell (
         .clock(clock), .reset(reset),
         .side_i(m_side[k]), .rem_i(m_rem[k]), .nq_i(m_nq[k]), .div_i(m_div[k]),
         .side_o(m_side[k+1]), .rem_o(m_rem[k+1]), .nq_o(m_nq[k+1]),
         .div_o(m_div[k+1])
      );
   end

   // angle as a fraction of a turn: (r * 2^32) / fs
   side_type          t_side [0:TURN_W];
   logic [FS_W-1:0]   t_rem  [0:TURN_W];
   logic [TURN_W-1:0] t_nq   [0:TURN_W];
   logic [FS_W-1:0]   t_div  [0:TURN_W];

   assign t_side[0] = m_side[FC_W];
   assign t_rem[0]  = m_rem[FC_W];
   assign t_nq[0]   = '0;
   assign t_div[0]  = m_div[FC_W];

   for (genvar k = 0; k < TURN_W; k++) begin : g_turn
      solp_div_cell #(.NW(TURN_W), .DW(FS_W)) u_cell (
         .clock(clock), .reset(reset),
         .side_i(t_side[k]), .rem_i(t_rem[k]), .nq_i(t_nq[k]), .div_i(t_div[k]),
         .side_o(t_side[k+1]), .rem_o(t_rem[k+1]), .nq_o(t_nq[k+1]),
         .div_o(t_div[k+1])
      );
   end

   // quadrant fold into the cordic range
   logic [TURN_W-1:0]      turn;
   logic signed [CV_W-1:0] a_in, a1_ff;
   logic                   flip_in;
   side_type               j1_in, j1_ff;

   assign turn = t_nq[TURN_W];

   always_comb begin
      flip_in = 1'b0;
      if (turn >= 32'hC000_0000) begin
         a_in = $signed({{(CV_W-TURN_W){turn[TURN_W-1]}}, turn});
      end else if (turn >= 32'h4000_0000) begin
         a_in    = $signed({{(CV_W-TURN_W){1'b0}}, turn}) - 34'sh0_8000_0000;
         flip_in = 1'b1;
      end else begin
         a_in = $signed({{(CV_W-TURN_W){1'b0}}, turn});
      end
      j1_in      = t_side[TURN_W];
      j1_in.flip = flip_in;
   end

   always_ff @(posedge clock) begin
      a1_ff <= a_in;
      if (reset) begin
         j1_ff <= '0;
      end else begin
         j1_ff <= j1_in;
      end
   end

   // cordic rotation chain
   side_type               c_side [0:CORDIC_ITERATIONS];
   logic signed [CV_W-1:0] c_x    [0:CORDIC_ITERATIONS];
   logic signed [CV_W-1:0] c_y    [0:CORDIC_ITERATIONS];
   logic signed [CV_W-1:0] c_a    [0:CORDIC_ITERATIONS];

   assign c_side[0] = j1_ff;
   assign c_x[0]    = CORDIC_GAIN;
   assign c_y[0]    = '0;
   assign c_a[0]    = a1_ff;

   for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_cordic
      solp_cordic_cell #(.IDX(k)) u_cell (
         .clock(clock), .reset(reset),
         .side_i(c_side[k]), .x_i(c_x[k]), .y_i(c_y[k]), .a_i(c_a[k]),
         .side_o(c_side[k+1]), .x_o(c_x[k+1]), .y_o(c_y[k+1]), .a_o(c_a[k+1])
      );
   end

   // sin and cos with the fold undone, sine magnitude for the q division
   logic signed [CV_W-1:0] sin_w, cos_w;
   logic [CV_W-1:0]        smag;
   logic [DS_NW-1:0]       ds_num_ff;
   side_type               j2_in, j2_ff;

   always_comb begin
      sin_w = c_side[CORDIC_ITERATIONS].flip ? -c_y[CORDIC_ITERATIONS]
                                             : c_y[CORDIC_ITERATIONS];
      cos_w = c_side[CORDIC_ITERATIONS].flip ? -c_x[CORDIC_ITERATIONS]
                                             : c_x[CORDIC_ITERATIONS];
      smag  = sin_w[CV_W-1] ? CV_W'(-sin_w) : CV_W'(sin_w);
      j2_in      = c_side[CORDIC_ITERATIONS];
      j2_in.sneg = sin_w[CV_W-1];
      j2_in.c    = cos_w[C_W-1:0];
   end

   always_ff @(posedge clock) begin
      ds_num_ff <= {smag[C_W-1:0], 7'b0};
      if (reset) begin
         j2_ff <= '0;
      end else begin
         j2_ff <= j2_in;
      end
   end

   // ds = sin * 128 / q, on magnitudes
   side_type         d_side [0:DS_NW];
   logic [Q_W-1:0]   d_rem  [0:DS_NW];
   logic [DS_NW-1:0] d_nq   [0:DS_NW];
   logic [Q_W-1:0]   d_div  [0:DS_NW];

   assign d_side[0] = j2_ff;
   assign d_rem[0]  = '0;
   assign d_nq[0]   = ds_num_ff;
   assign d_div[0]  = j2_ff.q;

   for (genvar k = 0; k < DS_NW; k++) begin : g_ds
      solp_div_cell #(.NW(DS_NW), .DW(Q_W)) u_cell (
         .clock(clock), .reset(reset),
         .side_i(d_side[k]), .rem_i(d_rem[k]), .nq_i(d_nq[k]), .div_i(d_div[k]),
         .side_o(d_side[k+1]), .rem_o(d_rem[k+1]), .nq_o(d_nq[k+1]),
         .div_o(d_div[k+1])
      );
   end

   // numerator and denominator of beta
   logic signed [BD_W-1:0] ds_w, num_w, den_w;
   logic [BD_W-1:0]        n_ff, dd_ff;
   side_type               j3_in, j3_ff;

   always_comb begin
      ds_w  = d_side[DS_NW].sneg ? -$signed({2'b00, d_nq[DS_NW]})
                                 : $signed({2'b00, d_nq[DS_NW]});
      num_w = 41'sh0_4000_0000 - ds_w;
      den_w = 41'sh0_4000_0000 + ds_w;
      j3_in      = d_side[DS_NW];
      j3_in.negb = (den_w != '0) && (num_w[BD_W-1] != den_w[BD_W-1]);
   end

   always_ff @(posedge clock) begin
      n_ff  <= num_w[BD_W-1] ? BD_W'(-num_w) : BD_W'(num_w);
      dd_ff <= den_w[BD_W-1] ? BD_W'(-den_w) : BD_W'(den_w);
      if (reset) begin
         j3_ff <= '0;
      end else begin
         j3_ff <= j3_in;
      end
   end

   // saturation check and beta divider set-up
   logic [BD_W-1:0] b_rem0_ff, b_div0_ff;
   logic [BQ_W-1:0] b_nq0_ff;
   side_type        j4_in, j4_ff;

   always_comb begin
      j4_in     = j3_ff;
      j4_in.sat = (dd_ff == '0) || ({3'b000, n_ff} >= {dd_ff, 3'b000});
   end

   always_ff @(posedge clock) begin
      b_rem0_ff <= {3'b000, n_ff[BD_W-1:3]};
      b_nq0_ff  <= {n_ff[2:0], 29'b0};
      b_div0_ff <= dd_ff;
      if (reset) begin
         j4_ff <= '0;
      end else begin
         j4_ff <= j4_in;
      end
   end

   // beta = |num| / (2 |den|) in q30
   side_type        b_side [0:BQ_W];
   logic [BD_W-1:0] b_rem  [0:BQ_W];
   logic [BQ_W-1:0] b_nq   [0:BQ_W];
   logic [BD_W-1:0] b_div  [0:BQ_W];

   assign b_side[0] = j4_ff;
   assign b_rem[0]  = b_rem0_ff;
   assign b_nq[0]   = b_nq0_ff;
   assign b_div[0]  = b_div0_ff;

   for (genvar k = 0; k < BQ_W; k++) begin : g_beta
      solp_div_cell #(.NW(BQ_W), .DW(BD_W)) u_cell (
         .clock(clock), .reset(reset),
         .side_i(b_side[k]), .rem_i(b_rem[k]), .nq_i(b_nq[k]), .div_i(b_div[k]),
         .side_o(b_side[k+1]), .rem_o(b_rem[k+1]), .nq_o(b_nq[k+1]),
         .div_o(b_div[k+1])
      );
   end

   // signed beta, saturated to four on overflow
   logic signed [BETA_W-1:0] bmag, beta_ff;
   side_type                 j5_ff;

   assign bmag = b_side[BQ_W].sat ? 35'sh1_0000_0000
                                  : $signed({3'b000, b_nq[BQ_W]});

   always_ff @(posedge clock) begin
      beta_ff <= b_side[BQ_W].negb ? -bmag : bmag;
      if (reset) begin
         j5_ff <= '0;
      end else begin
         j5_ff <= b_side[BQ_W];
      end
   end

   solp_coef_calc #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_coef (
      .clock(clock), .reset(reset),
      .side_i(j5_ff), .beta_i(beta_ff),
      .strobe_o(rsp_strobe), .rsp_o(rsp_data)
   );

   // checks
   `include "assert_macros.svh"

   `SOLP_ASSERT_ALWAYS(a_quiet_after_reset, $past(reset) |-> !rsp_strobe)
   `SOLP_ASSERT_RUN(a_latency, rsp_strobe |-> $past(start, LATENCY))
   `SOLP_ASSERT_RUN(a_zero_when_not_computed, (rsp_strobe && !rsp_data.computed) |-> ((rsp_data.coef_a0 == '0) && (rsp_data.coef_b1 == '0) && (rsp_data.coef_b2 == '0)))

endmodule

`default_nettype wire

// File: tb/second_order_lpf_hpf_coefficient_calc_unit_tb.sv
// ---------------------------------------------------------------------------
// second_order_lpf_hpf_coefficient_calc_unit_tb
// Drives low-pass, high-pass and unsupported coefficient requests over
// several sample rates. Each accepted request goes through a bit-exact
// fixed-point predictor, and every result strobe is checked against the
// oldest predicted coefficient set.
// ---------------------------------------------------------------------------
`default_nettype none

module second_order_lpf_hpf_coefficient_calc_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import solp_pkg::*;

   localparam int  LATENCY    = 128 + CORDIC_ITERATIONS_DEF;
   localparam int  STALL_MAX  = 5000;
   localparam int  RND_SHIFT  = 30 - COEF_FRAC_BITS_DEF;
   localparam longint ONE_Q30  = 64'sd1 << 30;
   localparam longint HALF_Q30 = 64'sd1 << 29;
   localparam longint COEF_HI  = (64'sd1 << (COEF_W - 1)) - 1;
   localparam longint COEF_LO  = -(64'sd1 << (COEF_W - 1));

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [FS_W-1:0]     csr_data;

   // predictor copy of the sample rate register
   logic [FS_W-1:0]     rate_hz;
   rsp_type             pending_coefs[$];
   int                  error_count;
   int                  quiet_cycles;
   bit                  allow_gaps;

   second_order_lpf_hpf_coefficient_calc_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // round a q30 value to the output format and saturate
   function automatic logic signed [COEF_W-1:0] round_coef(longint v, inout bit ovf);
      longint r;
      r = (v + (64'sd1 << (RND_SHIFT - 1))) >>> RND_SHIFT;
      if (r > COEF_HI) begin
         r = COEF_HI;
         ovf = 1'b1;
      end
      if (r < COEF_LO) begin
         r = COEF_LO;
         ovf = 1'b1;
      end
      return r[COEF_W-1:0];
   endfunction

   // fixed-point biquad coefficients for one request
   function automatic rsp_type biquad_coefs(req_type rq, logic [FS_W-1:0] fs);
      rsp_type           res;
      bit                ovf;
      bit                flip;
      longint unsigned   turn, n, dd, quo, rem;
      longint            ang, x, y, nx, s, c, q, ds, num, den, beta, gamma, alpha, a1;
      int                i;
      res = '0;
      ovf = 1'b0;
      if (rq.opcode != OP_LPF && rq.opcode != OP_HPF) return res;
      if (fs == 0) begin
         res.overflow = 1'b1;
         return res;
      end
      q = longint'(rq.quality);
      if (q == 0) q = longint'(Q_DEFAULT);

      // angle as a fraction of a full turn, then cordic rotation
      turn = ((longint'(rq.cutoff_hz) % longint'(fs)) << 32) / longint'(fs);
      ang  = longint'({32'b0, turn[31:0]});
      flip = 1'b0;
      if (ang >= 3 * ONE_Q30) ang = ang - (64'sd1 << 32);
      else if (ang >= ONE_Q30) begin
         ang  = ang - (64'sd1 << 31);
         flip = 1'b1;
      end
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (i = 0; i < CORDIC_ITERATIONS_DEF && i < 32; i++) begin
         if (ang >= 0) begin
            nx  = x - (y >>> i);
            y   = y + (x >>> i);
            ang = ang - longint'({32'b0, ATAN_TURN[i]});
         end else begin
            nx  = x + (y >>> i);
            y   = y - (x >>> i);
            ang = ang + longint'({32'b0, ATAN_TURN[i]});
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;

      // beta = (1-ds)/(2(1+ds)), saturated on a tiny denominator
      ds  = (s * 128) / q;
      num = ONE_Q30 - ds;
      den = ONE_Q30 + ds;
      n   = (num < 0) ? -num : num;
      dd  = (den < 0) ? -den : den;
      if (dd == 0 || n >= 8 * dd) begin
         beta = 4 * ONE_Q30;
         ovf  = 1'b1;
      end else begin
         quo = n / dd;
         rem = n % dd;
         for (i = 0; i < 29; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= dd) begin
               rem = rem - dd;
               quo = quo | 1;
            end
         end
         beta = longint'(quo);
      end
      if (dd != 0 && ((num < 0) != (den < 0))) beta = -beta;

      gamma = ((HALF_Q30 + beta) * c) >>> 30;
      if (rq.opcode == OP_LPF) begin
         alpha = (HALF_Q30 + beta - gamma) >>> 1;
         a1    = 2 * alpha;
      end else begin
         alpha = (HALF_Q30 + beta + gamma) >>> 1;
         a1    = -2 * alpha;
      end

      res.coef_a0  = round_coef(alpha, ovf);
      res.coef_a1  = round_coef(a1, ovf);
      res.coef_a2  = round_coef(alpha, ovf);
      res.coef_b1  = round_coef(-2 * gamma, ovf);
      res.coef_b2  = round_coef(2 * beta, ovf);
      res.computed = 1'b1;
      res.overflow = ovf;
      return res;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_coefs.size() == 0) begin
            $error("unexpected result transaction %h", rsp_data);
            error_count++;
         end else begin
            want = pending_coefs.pop_front();
            if (rsp_data.coef_a0 !== want.coef_a0) begin
               $error("coef_a0 exp %0d got %0d", want.coef_a0, rsp_data.coef_a0);
               error_count++;
            end
            if (rsp_data.coef_a1 !== want.coef_a1) begin
               $error("coef_a1 exp %0d got %0d", want.coef_a1, rsp_data.coef_a1);
               error_count++;
            end
            if (rsp_data.coef_a2 !== want.coef_a2) begin
               $error("coef_a2 exp %0d got %0d", want.coef_a2, rsp_data.coef_a2);
               error_count++;
            end
            if (rsp_data.coef_b1 !== want.coef_b1) begin
               $error("coef_b1 exp %0d got %0d", want.coef_b1, rsp_data.coef_b1);
               error_count++;
            end
            if (rsp_data.coef_b2 !== want.coef_b2) begin
               $error("coef_b2 exp %0d got %0d", want.coef_b2, rsp_data.coef_b2);
               error_count++;
            end
            if (rsp_data.computed !== want.computed) begin
               $error("computed exp %0b got %0b", want.computed, rsp_data.computed);
               error_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow exp %0b got %0b", want.overflow, rsp_data.overflow);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // one request transaction, start is left high for a following item
   task automatic send_req(logic [OP_W-1:0] op, logic [FC_W-1:0] fc, logic [Q_W-1:0] qv);
      req_type rq;
      int      gap;
      rq.opcode    = op;
      rq.cutoff_hz = fc;
      rq.quality   = qv;
      if (allow_gaps && $urandom_range(99) < 31) begin
         gap = $urandom_range(8, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      pending_coefs.push_back(biquad_coefs(rq, rate_hz));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_coefs.size() != 0) @(posedge clock);
   endtask

   task automatic write_rate(logic [FS_W-1:0] fs);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= fs;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rate_hz = fs;
   endtask

   // random request, mostly supported types at sane cutoffs and q
   task automatic send_random();
      logic [OP_W-1:0] op;
      logic [FC_W-1:0] fc;
      logic [Q_W-1:0]  qv;
      op = ($urandom_range(9) == 0) ? OP_W'($urandom_range(3, 2))
                                    : OP_W'($urandom_range(1));
      if ($urandom_range(9) < 8 && rate_hz > 2)
         fc = FC_W'($urandom_range(rate_hz / 2, 1));
      else
         fc = FC_W'($urandom());
      case ($urandom_range(9))
         0: qv = Q_W'($urandom());
         1: qv = Q_W'($urandom_range(127));
         2: qv = 16'd0;
         default: qv = Q_W'($urandom_range(4096, 64));
      endcase
      send_req(op, fc, qv);
   endtask

   task automatic test_directed();
      send_req(OP_LPF, 17'd1, 16'd181);
      send_req(OP_HPF, 17'd1, 16'd181);
      send_req(OP_LPF, 17'd1000, 16'd0);
      send_req(OP_HPF, 17'd1000, 16'd0);
      send_req(2'd2, 17'd1000, 16'd181);
      send_req(2'd3, 17'h1FFFF, 16'hFFFF);
      send_req(OP_LPF, 17'd24000, 16'd256);
      send_req(OP_HPF, 17'd24000, 16'd256);
      send_req(OP_LPF, 17'd96000, 16'd181);
      send_req(OP_HPF, 17'h1FFFF, 16'hFFFF);
      send_req(OP_LPF, 17'd0, 16'd1);
      send_req(OP_HPF, 17'd12000, 16'd1);
      // sine of -1 with q 0.5 zeroes the beta denominator
      send_req(OP_LPF, 17'd36000, 16'd128);
      send_req(OP_HPF, 17'd36000, 16'd128);
      send_req(OP_LPF, 17'd36000, 16'd100);
      send_req(OP_HPF, 17'd40000, 16'd1);
      send_req(OP_LPF, 17'd48000, 16'd181);
      send_req(OP_LPF, 17'd12000, 16'hFFFF);
      send_req(OP_HPF, 17'd20000, 16'h8000);
      send_req(OP_LPF, 17'h15555, 16'h5555);
      send_req(OP_HPF, 17'h0AAAA, 16'hAAAA);
   endtask

   task automatic test_rate_sweep();
      logic [FS_W-1:0] rates[6];
      int              k, j;
      rates = '{18'd8000, 18'd192000, 18'h3FFFF, 18'd0, 18'd1, 18'd44100};
      for (k = 0; k < 6; k++) begin
         write_rate(rates[k]);
         for (j = 0; j < 60; j++) send_random();
         send_req(OP_LPF, 17'h1FFFF, 16'd0);
         send_req(OP_HPF, 17'd1, 16'hFFFF);
      end
   endtask

   task automatic test_random_rates();
      int k, j;
      for (k = 0; k < 8; k++) begin
         write_rate(FS_W'($urandom_range(192000, 8000)));
         for (j = 0; j < 120; j++) send_random();
      end
      write_rate(18'd48000);
   endtask

   task automatic test_back_to_back();
      int j;
      allow_gaps = 1'b0;
      for (j = 0; j < 300; j++) send_random();
      allow_gaps = 1'b1;
   endtask

   // hold off until every coefficient set is back, then continue
   task automatic test_drain_pause();
      int j;
      for (j = 0; j < 20; j++) send_random();
      wait_drained();
      for (j = 0; j < 80; j++) send_random();
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      rate_hz       = FS_RESET;
      error_count   = 0;
      quiet_cycles  = 0;
      allow_gaps    = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_rate_sweep();
      test_random_rates();
      test_back_to_back();
      test_drain_pause();

      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
